>>> rtl/bpg_pkg.sv
package bpg_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_DEPTH   = 2'd0,
    CMD_LOAD_FEATURE = 2'd1,
    CMD_POINT        = 2'd2,
    CMD_EMPTY        = 2'd3
  } cmd_t;

  localparam int ScaleWidth = 32;
  localparam int SumWidth   = 32;
  localparam int ValueWidth = 16;
  localparam logic signed [ValueWidth-1:0] ValMax = 16'sd32767;
  localparam logic signed [ValueWidth-1:0] ValMin = -16'sd32768;

  // controller -> datapath
  typedef struct packed {
    logic read_stores;   // register the store-index range checks for an accepted transfer
    logic accumulate;    // add products of the registered store reads into sums
    logic mult;          // register sum * scale for the channel in emit_ch
    logic clear;         // zero the sums
  } dp_cmd_t;

endpackage

>>> rtl/bev_pool_gather_int16.sv
// Segmented weighted gather with requantization to signed 16 bits.
// Input channel: in_valid/in_stall carries one command per transfer. Load
// commands write the depth or feature store; a point reads both stores and
// adds weight * feature to each channel sum; a last point or an empty-pillar
// command closes the pillar and emits one result per channel, channel 0 first.
// Output channel: out_valid/out_stall; a result holds while out_stall is high.
// A load is written as it is transferred; a plain point reads the stores, then
// accumulates. Closing a pillar runs multiply, then present, for each channel,
// then one clear, waiting out any output stall; the block takes no new item
// until the close is done. Closing an out-of-range cell emits nothing.
// The first result is presented after the accumulate and multiply states that
// follow a last point, or after the multiply state alone for an empty pillar.
// Reset clears the channel sums and sets the gain register to 1.0; the stores
// are undefined until loaded. The gain is written through the APB port at
// address 0; the user must do so while idle; the block does not enforce it.
module bev_pool_gather_int16
  import bpg_pkg::*;
#(
  parameter int CHANNELS        = 8,
  parameter int WEIGHT_ENTRIES  = 4096,
  parameter int FEATURE_ENTRIES = 4096,
  parameter int GRID_CELLS      = 65536,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [11:0]           load_address,
  input  logic [7:0]            weight_value,
  input  logic [63:0]           feature_word,
  input  logic [11:0]           weight_index,
  input  logic [11:0]           feature_index,
  input  logic                  last_point,
  input  logic [15:0]           cell_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_cell,
  output logic [2:0]            out_channel,
  output logic signed [15:0]    out_value,
  output logic                  last_channel
);
  logic signed [31:0] gain;
  dp_cmd_t            cmd;
  logic               wload, fload;
  logic [2:0]         emit_ch;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? gain : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 32'sd65536;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      gain <= pwdata;
    end
  end

  bpg_ctrl #(.Channels(CHANNELS), .GridCells(GRID_CELLS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .command, .last_point, .cell_index,
    .cmd, .wload, .fload, .emit_ch, .out_stall, .out_valid, .out_cell,
    .out_channel, .last_channel);

  bpg_datapath #(
    .Channels(CHANNELS), .WeightEntries(WEIGHT_ENTRIES),
    .FeatureEntries(FEATURE_ENTRIES), .ScaleFracBits(SCALE_FRAC_BITS)
  ) u_dp (
    .clk, .cmd, .wload, .fload, .load_address, .weight_value,
    .feature_word(feature_word[8*CHANNELS-1:0]), .weight_index, .feature_index,
    .scale(gain), .emit_ch, .value(out_value));
endmodule

>>> rtl/bpg_ram.sv
module bpg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bpg_datapath.sv
module bpg_datapath
  import bpg_pkg::*;
#(
  parameter int Channels       = 8,
  parameter int WeightEntries  = 4096,
  parameter int FeatureEntries = 4096,
  parameter int ScaleFracBits  = 16
) (
  input  logic                         clk,
  input  dp_cmd_t                      cmd,
  input  logic                         wload,
  input  logic                         fload,
  input  logic [11:0]                  load_address,
  input  logic [7:0]                   weight_value,
  input  logic [8*Channels-1:0]        feature_word,
  input  logic [11:0]                  weight_index,
  input  logic [11:0]                  feature_index,
  input  logic signed [ScaleWidth-1:0] scale,
  input  logic [2:0]                   emit_ch,
  output logic signed [ValueWidth-1:0] value
);
  localparam int WaBits = $clog2(WeightEntries);
  localparam int FaBits = $clog2(FeatureEntries);

  logic [7:0]              wrd;
  logic [8*Channels-1:0]   frd;
  logic                    w_ok, f_ok, w_ok_q, f_ok_q;
  logic signed [SumWidth-1:0] sums [Channels];
  logic signed [63:0]      prod;
  logic signed [63:0]      rnd;
  logic signed [63:0]      q;

  bpg_ram #(.Width(8), .Depth(WeightEntries)) u_wram (
    .clk, .we(wload && (32'(load_address) < WeightEntries)),
    .waddr(WaBits'(load_address)), .wdata(weight_value),
    .raddr(WaBits'(weight_index)), .rdata(wrd));

  bpg_ram #(.Width(8*Channels), .Depth(FeatureEntries)) u_fram (
    .clk, .we(fload && (32'(load_address) < FeatureEntries)),
    .waddr(FaBits'(load_address)), .wdata(feature_word),
    .raddr(FaBits'(feature_index)), .rdata(frd));

  assign w_ok = 32'(weight_index) < WeightEntries;
  assign f_ok = 32'(feature_index) < FeatureEntries;

  always_ff @(posedge clk) begin
    if (cmd.read_stores) begin
      w_ok_q <= w_ok;
      f_ok_q <= f_ok;
    end
  end

  // per-channel 8x8 products are narrow; one adder per lane
  always_ff @(posedge clk) begin
    for (int c = 0; c < Channels; c++) begin
      if (cmd.clear) begin
        sums[c] <= '0;
      end else if (cmd.accumulate && w_ok_q && f_ok_q) begin
        sums[c] <= sums[c] + SumWidth'($signed({1'b0, wrd})) *
                             SumWidth'($signed(frd[8*c +: 8]));
      end
    end
    if (cmd.mult) begin
      prod <= 64'(sums[emit_ch[$clog2(Channels > 1 ? Channels : 2)-1:0]]) * 64'(scale);
    end
  end

  always_comb begin
    if (ScaleFracBits > 0) begin
      rnd = prod + (64'sd1 <<< (ScaleFracBits - 1));
    end else begin
      rnd = prod;
    end
    q = rnd >>> ScaleFracBits;
    if (q > 64'(ValMax)) begin
      value = ValMax;
    end else if (q < 64'(ValMin)) begin
      value = ValMin;
    end else begin
      value = q[ValueWidth-1:0];
    end
  end
endmodule

>>> rtl/bpg_ctrl.sv
module bpg_ctrl
  import bpg_pkg::*;
#(
  parameter int Channels  = 8,
  parameter int GridCells = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        last_point,
  input  logic [15:0] cell_index,
  output dp_cmd_t     cmd,
  output logic        wload,
  output logic        fload,
  output logic [2:0]  emit_ch,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [15:0] out_cell,
  output logic [2:0]  out_channel,
  output logic        last_channel
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_MUL  = 5'b00100,
    S_OUT  = 5'b01000,
    S_CLR  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic        close_q, emit_q;
  logic [15:0] cell_q;
  logic        acc;
  logic        cell_ok;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cell_ok  = 32'(cell_index) < GridCells;
  assign wload    = acc && (command == CMD_LOAD_DEPTH);
  assign fload    = acc && (command == CMD_LOAD_FEATURE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.read_stores = acc;
    case (state)
      S_IDLE: begin
        if (acc && command == CMD_POINT) begin
          state_next = S_ACC;
        end else if (acc && command == CMD_EMPTY) begin
          state_next = cell_ok ? S_MUL : S_CLR;
        end
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next = !close_q ? S_IDLE : (emit_q ? S_MUL : S_CLR);
      end
      S_MUL: begin
        cmd.mult = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = (32'(emit_ch) == Channels - 1) ? S_CLR : S_MUL;
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // zero the sums while in reset
    if (rst) begin
      cmd.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      emit_ch <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        emit_ch <= '0;
      end else if (state == S_OUT && !out_stall) begin
        emit_ch <= emit_ch + 3'd1;
      end
    end
    if (acc) begin
      close_q <= last_point;
      emit_q  <= cell_ok;
      cell_q  <= cell_index;
    end
  end

  assign out_valid    = (state == S_OUT);
  assign out_cell     = cell_q;
  assign out_channel  = emit_ch;
  assign last_channel = (32'(emit_ch) == Channels - 1);
endmodule
